/* design/itda_pkg.sv */
// ----------------------------------------------------------------------------
// itda_pkg
// Shared widths, character codes and transaction types for the
// integer-to-decimal ASCII unit.
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int STEP_BITS  = 4;
    localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = STEPS * STEP_BITS;
    localparam int RADIX      = 10;

    // Count the decimal digits of the largest magnitude, 2**(VALUE_BITS-1).
    function automatic int calc_digits();
        longint unsigned v;
        int              n;
        v = 64'd1 << (VALUE_BITS - 1);
        n = 0;
        for (int i = 0; i < 20; i++)
        begin
            if (v != 0)
            begin
                n = n + 1;
                v = v / RADIX;
            end
        end
        return n;
    endfunction

    localparam int DIGITS     = calc_digits();
    localparam int CNT_BITS   = $clog2(DIGITS + 2);
    localparam int STEP_CNT_BITS = $clog2(STEPS);

    localparam logic [6:0] CH_PLUS  = 7'd43;
    localparam logic [6:0] CH_MINUS = 7'd45;
    localparam logic [6:0] CH_ZERO  = 7'd48;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] number;
        logic                         plus_forced;
    } value_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic [3:0] run_len;
        logic       last;
    } text_t;

    // Command to every cell of the digit chain
    typedef struct packed {
        logic clear;
        logic convert;
        logic shift;
    } cell_ctl_t;

endpackage

/* design/itda_digit_cell.sv */
// ----------------------------------------------------------------------------
// itda_digit_cell
// One BCD digit of the conversion chain: shift-and-add-3 on a nibble of
// incoming bits per cycle, or a plain move of the digit from the neighbor.
// ----------------------------------------------------------------------------
module itda_digit_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itda_pkg::cell_ctl_t           ctl,
    input  logic [itda_pkg::STEP_BITS-1:0] feed,
    input  logic [3:0]                    digit_in,
    output logic [itda_pkg::STEP_BITS-1:0] carry,
    output logic [3:0]                    digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] dabble;

    // Sub-step j consumes feed bit STEP_BITS-1-j, MSB first.
    always_comb
    begin
        dabble = digit_reg;
        carry  = '0;
        for (int j = 0; j < itda_pkg::STEP_BITS; j++)
        begin
            if (dabble >= 4'd5)
            begin
                dabble = 4'(dabble + 4'd3);
            end
            carry[itda_pkg::STEP_BITS-1-j] = dabble[3];
            dabble = {dabble[2:0], feed[itda_pkg::STEP_BITS-1-j]};
        end
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctl.convert)
        begin
            digit_next = dabble;
        end
        else if (ctl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

/* design/itda_digit_chain.sv */
// ----------------------------------------------------------------------------
// itda_digit_chain
// Row of BCD digit cells, least significant at index 0; the top cell
// presents the digit that goes out next.
// ----------------------------------------------------------------------------
module itda_digit_chain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  itda_pkg::cell_ctl_t            ctl,
    input  logic [itda_pkg::STEP_BITS-1:0] feed,
    output logic [3:0]                     top_digit
);

    logic [itda_pkg::STEP_BITS-1:0] carry_w [itda_pkg::DIGITS];
    logic [3:0]                     digit_w [itda_pkg::DIGITS];

    for (genvar i = 0; i < itda_pkg::DIGITS; i++)
    begin : g_cell
        logic [itda_pkg::STEP_BITS-1:0] feed_w;
        logic [3:0]                     below_w;

        if (i == 0)
        begin : g_first
            assign feed_w  = feed;
            assign below_w = 4'd0;
        end
        else
        begin : g_rest
            assign feed_w  = carry_w[i-1];
            assign below_w = digit_w[i-1];
        end

        itda_digit_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .feed     (feed_w),
            .digit_in (below_w),
            .carry    (carry_w[i]),
            .digit    (digit_w[i])
        );
    end

    assign top_digit = digit_w[itda_pkg::DIGITS-1];

endmodule

/* design/int_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Converts one signed integer to its decimal ASCII text, one character per
// output transaction, most significant first.
//
// One value is taken at a time: value_ready is high only while the unit
// is idle. The magnitude is fed into a chain of DIGITS BCD cells, STEP_BITS
// bits per cycle, then the chain shifts out its leading zeros one digit per
// cycle, then the sign (if any) and the digits leave one per cycle while
// text_ready is high. Every character carries the length of the whole run and
// the final one carries last; the most negative value prints its true
// magnitude.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             value_valid,
    output logic             value_ready,
    input  itda_pkg::value_t value,
    output logic             text_valid,
    input  logic             text_ready,
    output itda_pkg::text_t  text
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [itda_pkg::PAD_BITS-1:0]      mag_reg;
    logic [itda_pkg::PAD_BITS-1:0]      mag_next;
    logic [itda_pkg::STEP_CNT_BITS-1:0] step_reg;
    logic [itda_pkg::STEP_CNT_BITS-1:0] step_next;
    logic [itda_pkg::CNT_BITS-1:0]      skip_reg;
    logic [itda_pkg::CNT_BITS-1:0]      skip_next;
    logic [itda_pkg::CNT_BITS-1:0]      remain_reg;
    logic [itda_pkg::CNT_BITS-1:0]      remain_next;
    logic [itda_pkg::CNT_BITS-1:0]      total_reg;
    logic [itda_pkg::CNT_BITS-1:0]      total_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic                               sign_on_reg;
    logic                               sign_on_next;

    logic [itda_pkg::VALUE_BITS-1:0]    raw;
    logic [itda_pkg::VALUE_BITS-1:0]    abs_val;
    logic                               raw_neg;
    logic                               value_acc;
    logic                               text_acc;
    logic                               skip_more;
    itda_pkg::cell_ctl_t                ctl;
    logic [3:0]                         top_digit;

    assign value_ready = (state_reg == S_IDLE);
    assign text_valid  = (state_reg == S_SIGN) || (state_reg == S_DIGIT);
    assign value_acc   = value_valid && value_ready;
    assign text_acc    = text_valid && text_ready;

    // Two's complement negate in unsigned form: the most negative value
    // becomes its true magnitude.
    assign raw     = value.number;
    assign raw_neg = raw[itda_pkg::VALUE_BITS-1];
    assign abs_val = raw_neg ? itda_pkg::VALUE_BITS'(~raw + 1'b1) : raw;

    // Drop a leading zero while more than one digit remains.
    assign skip_more = (top_digit == 4'd0) &&
                       (skip_reg != itda_pkg::CNT_BITS'(itda_pkg::DIGITS - 1));

    always_comb
    begin
        ctl         = '0;
        state_next  = state_reg;
        mag_next    = mag_reg;
        step_next   = step_reg;
        skip_next   = skip_reg;
        remain_next = remain_reg;
        total_next  = total_reg;
        neg_next    = neg_reg;
        sign_on_next = sign_on_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (value_acc)
                begin
                    ctl.clear    = 1'b1;
                    mag_next     = itda_pkg::PAD_BITS'(abs_val);
                    neg_next     = raw_neg;
                    sign_on_next = raw_neg || value.plus_forced;
                    step_next    = '0;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                // Advance the chain by one nibble, MSB first.
                ctl.convert = 1'b1;
                mag_next    = {mag_reg[itda_pkg::PAD_BITS-itda_pkg::STEP_BITS-1:0],
                               {itda_pkg::STEP_BITS{1'b0}}};
                step_next   = itda_pkg::STEP_CNT_BITS'(step_reg + 1'b1);
                if (step_reg == itda_pkg::STEP_CNT_BITS'(itda_pkg::STEPS - 1))
                begin
                    skip_next  = '0;
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (skip_more)
                begin
                    ctl.shift = 1'b1;
                    skip_next = itda_pkg::CNT_BITS'(skip_reg + 1'b1);
                end
                else
                begin
                    remain_next = itda_pkg::CNT_BITS'(itda_pkg::DIGITS) - skip_reg;
                    total_next  = itda_pkg::CNT_BITS'(itda_pkg::DIGITS) - skip_reg
                                  + itda_pkg::CNT_BITS'(sign_on_reg);
                    state_next  = sign_on_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN:
            begin
                if (text_acc)
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (text_acc)
                begin
                    ctl.shift   = 1'b1;
                    remain_next = itda_pkg::CNT_BITS'(remain_reg - 1'b1);
                    if (remain_reg == itda_pkg::CNT_BITS'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            skip_reg    <= '0;
            remain_reg  <= '0;
            total_reg   <= '0;
            neg_reg     <= 1'b0;
            sign_on_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            skip_reg    <= skip_next;
            remain_reg  <= remain_next;
            total_reg   <= total_next;
            neg_reg     <= neg_next;
            sign_on_reg <= sign_on_next;
        end
    end

    // Magnitude shift register is payload only.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

    itda_digit_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .feed      (mag_reg[itda_pkg::PAD_BITS-1 -: itda_pkg::STEP_BITS]),
        .top_digit (top_digit)
    );

    // Output fields come straight from registers, so they hold while stalled.
    always_comb
    begin
        text.run_len = 4'(total_reg);
        if (state_reg == S_SIGN)
        begin
            text.char_code = neg_reg ? itda_pkg::CH_MINUS : itda_pkg::CH_PLUS;
            text.last      = (total_reg == itda_pkg::CNT_BITS'(1));
        end
        else
        begin
            text.char_code = 7'(itda_pkg::CH_ZERO + {3'b000, top_digit});
            text.last      = (remain_reg == itda_pkg::CNT_BITS'(1));
        end
    end

    // Never take a new value while a character is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(value_ready && text_valid))
        else $error("value accepted while text pending");

    // The final character of a run returns the unit to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text.last |=> value_ready)
        else $error("unit not idle after last character");

    // While digits go out, the remaining count stays within the chain.
    a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT) |->
            (remain_reg != '0) &&
            (remain_reg <= itda_pkg::CNT_BITS'(itda_pkg::DIGITS)))
        else $error("digit count out of range");

    // A sign character appears only ahead of at least one digit.
    a_sign_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIGN) |-> (total_reg == remain_reg + 1'b1) && !text.last)
        else $error("sign character total mismatch");

endmodule
